@@ design/apdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apdc_pkg;

  // Cascade geometry
  localparam int STAGES    = 8;
  localparam int LINE_SIZE = 4096;
  localparam int LINE_W    = $clog2(LINE_SIZE);
  localparam int STAGE_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int MEM_DEPTH = STAGES * LINE_SIZE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int DLY_W     = 12;
  localparam int DLY_PER_REG = 4;
  localparam int CFG_W     = DLY_W * DLY_PER_REG;
  localparam int CFG_IDX_W = 2;

  // Delay clamp
  localparam int DELAY_MIN = 10;
  localparam int CMP_W     = ((LINE_W > DLY_W) ? LINE_W : DLY_W) + 1;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd22938;
  localparam logic [CFG_W-1:0]         DLY_RST  = 48'h3E8_3E8_3E8_3E8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DLY_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DLY_B = 2'd2;

endpackage

`default_nettype wire

@@ design/apdc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apdc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/apdc_gain_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared gain unit: registered product a*g, then round to Q1.23,
// add to or subtract from a base and saturate to 24 bits.
module apdc_gain_mac (
  input  wire logic                                clk,
  input  wire logic                                mul_en,
  input  wire logic signed [apdc_pkg::SAMPLE_W-1:0] mul_a,
  input  wire logic signed [apdc_pkg::GAIN_W-1:0]   mul_g,
  input  wire logic signed [apdc_pkg::SAMPLE_W-1:0] add_base,
  input  wire logic                                add_sub,
  output logic signed      [apdc_pkg::SAMPLE_W-1:0] result
);

  localparam int RND_W = apdc_pkg::PROD_W + 1 - 15;
  localparam int SUM_W = RND_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(8388608);

  logic signed [apdc_pkg::PROD_W-1:0] prod_r;
  logic signed [apdc_pkg::PROD_W-1:0] prod_nxt;
  logic signed [apdc_pkg::PROD_W:0]   biased;
  logic signed [RND_W-1:0]            rnd;
  logic signed [SUM_W-1:0]            sum;

  // Multiply stage
  assign prod_nxt = mul_a * mul_g;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Round half up: add 2^14, floor shift by 15
  assign biased = {prod_r[apdc_pkg::PROD_W-1], prod_r} + (apdc_pkg::PROD_W + 1)'(16384);
  assign rnd    = biased[apdc_pkg::PROD_W:15];

  always_comb begin
    if (add_sub) begin
      sum = SUM_W'(add_base) - SUM_W'(rnd);
    end else begin
      sum = SUM_W'(add_base) + SUM_W'(rnd);
    end
    if (sum > SAT_HI) begin
      result = SAT_HI[apdc_pkg::SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      result = SAT_LO[apdc_pkg::SAMPLE_W-1:0];
    end else begin
      result = sum[apdc_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/allpass_diffuser_cascade_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Eight-stage Schroeder allpass diffuser for signed Q1.23 samples. All stage
// delay lines share one single-port-write, registered-read memory and all
// multiplies go through one 24x16 multiplier, so each stage steps through
// read, multiply d*g, add and store v, multiply v*g and subtract, in that
// order. A new item is taken only once the previous one has been written to
// the output register. After reset the block clears all STAGES*LINE_SIZE =
// 32768 delay memory entries, one entry a cycle, before it takes the first item;
// configuration writes are taken at any time, but should only be made while
// no item is in flight.
module allpass_diffuser_cascade_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [apdc_pkg::SAMPLE_W-1:0]    in_sample_in,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed      [apdc_pkg::SAMPLE_W-1:0]    out_sample_out,
  input  wire logic                                    cfg_we,
  input  wire logic        [apdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [apdc_pkg::CFG_W-1:0]       cfg_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL_D,
    ST_ADD_V,
    ST_MUL_V,
    ST_ADD_X,
    ST_DONE
  } state_t;

  localparam int LW  = apdc_pkg::LINE_W;
  localparam int AW  = apdc_pkg::ADDR_W;
  localparam int SW  = apdc_pkg::SAMPLE_W;
  localparam int CW  = apdc_pkg::CMP_W;

  state_t                              state_r;
  logic   [AW-1:0]                     clr_r;
  logic   [apdc_pkg::STAGE_W-1:0]      stage_r;
  logic   [LW-1:0]                     wp_r;
  logic signed [apdc_pkg::GAIN_W-1:0]  gain_r;
  logic   [apdc_pkg::CFG_W-1:0]        dly_a_r;
  logic   [apdc_pkg::CFG_W-1:0]        dly_b_r;
  logic signed [SW-1:0]                x_r;
  logic signed [SW-1:0]                d_r;
  logic signed [SW-1:0]                v_r;
  logic                                out_valid_r;
  logic signed [SW-1:0]                out_sample_r;

  logic   [2:0]                        dsel;
  logic   [apdc_pkg::DLY_W-1:0]        dly_raw;
  logic   [CW-1:0]                     dly_ext;
  logic   [LW-1:0]                     dly;
  logic   [LW:0]                       rd_sum;
  logic   [LW-1:0]                     rd_pos;
  logic   [AW-1:0]                     line_base;
  logic                                ram_we;
  logic   [AW-1:0]                     ram_waddr;
  logic   [SW-1:0]                     ram_wdata;
  logic                                ram_re;
  logic   [AW-1:0]                     ram_raddr;
  logic   [SW-1:0]                     ram_rdata;
  logic                                mul_en;
  logic signed [SW-1:0]                mul_a;
  logic signed [SW-1:0]                add_base;
  logic                                add_sub;
  logic signed [SW-1:0]                mac_res;
  logic                                out_free;

  // Delay of the current stage, picked by stage mod 8 and clamped
  always_comb begin
    dsel = 3'(stage_r);
    if (dsel[2]) begin
      dly_raw = dly_b_r[apdc_pkg::DLY_W*dsel[1:0] +: apdc_pkg::DLY_W];
    end else begin
      dly_raw = dly_a_r[apdc_pkg::DLY_W*dsel[1:0] +: apdc_pkg::DLY_W];
    end
    dly_ext = CW'(dly_raw);
    if (dly_ext < CW'(apdc_pkg::DELAY_MIN)) begin
      dly = LW'(apdc_pkg::DELAY_MIN);
    end else if (dly_ext > CW'(apdc_pkg::LINE_SIZE - apdc_pkg::DELAY_MIN)) begin
      dly = LW'(apdc_pkg::LINE_SIZE - apdc_pkg::DELAY_MIN);
    end else begin
      dly = dly_ext[LW-1:0];
    end
  end

  // Read position in the line: wp - delay, wrapped
  always_comb begin
    rd_sum = (LW + 1)'(wp_r) + (LW + 1)'(apdc_pkg::LINE_SIZE) - (LW + 1)'(dly);
    if (rd_sum >= (LW + 1)'(apdc_pkg::LINE_SIZE)) begin
      rd_pos = LW'(rd_sum - (LW + 1)'(apdc_pkg::LINE_SIZE));
    end else begin
      rd_pos = LW'(rd_sum);
    end
    line_base = AW'(stage_r) * AW'(apdc_pkg::LINE_SIZE);
  end

  // Memory port control: clearing sweep or stage access
  always_comb begin
    ram_re    = (state_r == ST_READ);
    ram_raddr = line_base + AW'(rd_pos);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == ST_ADD_V);
      ram_waddr = line_base + AW'(wp_r);
      ram_wdata = mac_res;
    end
  end

  // Shared multiplier operand and adder selection
  always_comb begin
    mul_en   = (state_r == ST_MUL_D) || (state_r == ST_MUL_V);
    mul_a    = (state_r == ST_MUL_D) ? $signed(ram_rdata) : v_r;
    add_sub  = (state_r == ST_ADD_X);
    add_base = (state_r == ST_ADD_X) ? d_r : x_r;
  end

  apdc_ram #(
    .WIDTH (SW),
    .DEPTH (apdc_pkg::MEM_DEPTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  apdc_gain_mac u_mac (
    .clk      (clk),
    .mul_en   (mul_en),
    .mul_a    (mul_a),
    .mul_g    (gain_r),
    .add_base (add_base),
    .add_sub  (add_sub),
    .result   (mac_res)
  );

  assign out_free       = !out_valid_r || !out_stall;
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      stage_r     <= '0;
      wp_r        <= '0;
      gain_r      <= apdc_pkg::GAIN_RST;
      dly_a_r     <= apdc_pkg::DLY_RST;
      dly_b_r     <= apdc_pkg::DLY_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          apdc_pkg::REG_GAIN:  gain_r  <= $signed(cfg_wdata[apdc_pkg::GAIN_W-1:0]);
          apdc_pkg::REG_DLY_A: dly_a_r <= cfg_wdata;
          apdc_pkg::REG_DLY_B: dly_b_r <= cfg_wdata;
          default: ;
        endcase
      end

      // drain the output register; ST_DONE refills it itself
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(apdc_pkg::MEM_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            stage_r <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          d_r     <= $signed(ram_rdata);
          state_r <= ST_ADD_V;
        end
        ST_ADD_V: begin
          v_r     <= mac_res;
          state_r <= ST_MUL_V;
        end
        ST_MUL_V: begin
          state_r <= ST_ADD_X;
        end
        ST_ADD_X: begin
          x_r <= mac_res;
          if (stage_r == apdc_pkg::STAGE_W'(apdc_pkg::STAGES - 1)) begin
            state_r <= ST_DONE;
          end else begin
            stage_r <= stage_r + apdc_pkg::STAGE_W'(1);
            state_r <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= x_r;
            if (wp_r == LW'(apdc_pkg::LINE_SIZE - 1)) begin
              wp_r <= '0;
            end else begin
              wp_r <= wp_r + LW'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
